// ===== rtl/lnclip_pkg.sv =====
`timescale 1ns / 1ps

package lnclip_pkg;

  // Register indexes on the configuration channel
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_NEAR_PLANE_Z  = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [30:0] NEAR_PLANE_Z_RST  = 31'd655;

  // Interpolation fraction bits and divider shapes
  localparam int T_BITS    = 31;
  localparam int CLIP_Q_W  = 32;
  localparam int CLIP_D_W  = 33;
  localparam int CLIP_N_W  = CLIP_D_W + T_BITS;
  localparam int PROJ_Q_W  = 18;
  localparam int PROJ_D_W  = 31;
  localparam int SUM_W     = 47;
  localparam int MAG_W     = SUM_W - 1;
  localparam int LANES     = 4;

  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] y0;
    logic [31:0] z0;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [31:0] z1;
    logic [13:0] focal;
    logic [31:0] colour;
    logic [30:0] nz;
    logic        drop;
    logic        clip_first;
    logic        clip_second;
    logic        dx_neg;
    logic [31:0] dx_mag;
    logic        dy_neg;
    logic [31:0] dy_mag;
  } seg_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             drop;
    logic [31:0]      colour;
  } proj_side_t;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/lnclip_div_pipe.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage.
// overflow flags a quotient that does not fit in Q_W bits.
module lnclip_div_pipe #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [Q_W-1:0]   quotient,
  output logic             overflow
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = HI_W + DEN_W;

  logic [DEN_W-1:0] rem  [0:Q_W];
  logic [DEN_W-1:0] den  [0:Q_W];
  logic [Q_W-1:0]   low  [0:Q_W];
  logic [Q_W-1:0]   quo  [0:Q_W];
  logic [Q_W:0]     ovf;

  logic [HI_W-1:0] hi;
  assign hi = dividend[NUM_W-1:Q_W];

  always_ff @(posedge clk) begin
    rem[0]  <= DEN_W'(hi);
    den[0]  <= divisor;
    low[0]  <= dividend[Q_W-1:0];
    quo[0]  <= '0;
    ovf[0]  <= CMP_W'(hi) >= CMP_W'(divisor);
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem[k-1], low[k-1][Q_W-1]};
    assign diff  = trial - {1'b0, den[k-1]};
    assign ge    = !diff[DEN_W];

    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      den[k] <= den[k-1];
      low[k] <= low[k-1] << 1;
      quo[k] <= (quo[k-1] << 1) | Q_W'(ge);
      ovf[k] <= ovf[k-1];
    end
  end

  assign quotient = quo[Q_W];
  assign overflow = ovf[Q_W];

endmodule

// ===== rtl/line_near_clip_perspective_project_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   -----------------------   ---------------------------------------------
// input     start / busy              start_x..end_z, focal_scale, line_colour
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
// result    done (one-cycle strobe)   visible, screen_x0..screen_y1, colour_out
//
// Fully pipelined: one segment per cycle while busy is low.
// The pipeline holds the 32-stage interpolation divider and the 18-stage
// projection dividers, one quotient bit per stage.
// busy is high only while rst is asserted; reset empties the pipeline.
// The receiver cannot stall, so done is a strobe and nothing in flight waits.
module line_near_clip_perspective_project_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                start_x,
  input  logic signed [31:0]                start_y,
  input  logic signed [31:0]                start_z,
  input  logic signed [31:0]                end_x,
  input  logic signed [31:0]                end_y,
  input  logic signed [31:0]                end_z,
  input  logic [13:0]                       focal_scale,
  input  logic [31:0]                       line_colour,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lnclip_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lnclip_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                              done,
  output logic                              visible,
  output logic signed [15:0]                screen_x0,
  output logic signed [15:0]                screen_y0,
  output logic signed [15:0]                screen_x1,
  output logic signed [15:0]                screen_y1,
  output logic [31:0]                       colour_out
);

  localparam int CLIP_LAT = lnclip_pkg::CLIP_Q_W + 1;
  localparam int PROJ_LAT = lnclip_pkg::PROJ_Q_W + 1;
  localparam int LATENCY  = 2 + CLIP_LAT + 6 + PROJ_LAT + 1;
  localparam int LANES    = lnclip_pkg::LANES;

  // ---------------- configuration ----------------
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [30:0] near_plane_z;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lnclip_pkg::SCREEN_WIDTH_RST;
      screen_height <= lnclip_pkg::SCREEN_HEIGHT_RST;
      near_plane_z  <= lnclip_pkg::NEAR_PLANE_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lnclip_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        lnclip_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        lnclip_pkg::REG_NEAR_PLANE_Z:  near_plane_z  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- S0: capture beat ----------------
  logic        v_s0;
  logic [31:0] s0_x0, s0_y0, s0_z0, s0_x1, s0_y1, s0_z1, s0_colour;
  logic [13:0] s0_focal;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
    end else begin
      v_s0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s0_x0     <= start_x;
      s0_y0     <= start_y;
      s0_z0     <= start_z;
      s0_x1     <= end_x;
      s0_y1     <= end_y;
      s0_z1     <= end_z;
      s0_focal  <= focal_scale;
      s0_colour <= line_colour;
    end
  end

  // ---------------- S1: near test, divider operands ----------------
  logic [30:0]        nz_eff;
  logic signed [32:0] nz_e, z0_e, z1_e, x0_e, x1_e, y0_e, y1_e;
  logic               c0, c1;
  logic [32:0]        num_sel, den_sel;
  lnclip_pkg::seg_t   s1_seg_next;

  always_comb begin
    nz_eff = (near_plane_z == '0) ? 31'd1 : near_plane_z;
    nz_e   = $signed({2'b00, nz_eff});
    z0_e   = $signed({s0_z0[31], s0_z0});
    z1_e   = $signed({s0_z1[31], s0_z1});
    x0_e   = $signed({s0_x0[31], s0_x0});
    x1_e   = $signed({s0_x1[31], s0_x1});
    y0_e   = $signed({s0_y0[31], s0_y0});
    y1_e   = $signed({s0_y1[31], s0_y1});
    c0     = z0_e < nz_e;
    c1     = z1_e < nz_e;

    if (c0 && !c1) begin
      num_sel = 33'(nz_e - z0_e);
      den_sel = 33'(z1_e - z0_e);
    end else if (c1 && !c0) begin
      num_sel = 33'(z0_e - nz_e);
      den_sel = 33'(z0_e - z1_e);
    end else begin
      num_sel = '0;
      den_sel = 33'd1;
    end

    s1_seg_next.x0          = s0_x0;
    s1_seg_next.y0          = s0_y0;
    s1_seg_next.z0          = s0_z0;
    s1_seg_next.x1          = s0_x1;
    s1_seg_next.y1          = s0_y1;
    s1_seg_next.z1          = s0_z1;
    s1_seg_next.focal       = s0_focal;
    s1_seg_next.colour      = s0_colour;
    s1_seg_next.nz          = nz_eff;
    s1_seg_next.drop        = c0 && c1;
    s1_seg_next.clip_first  = c0 && !c1;
    s1_seg_next.clip_second = c1 && !c0;
    s1_seg_next.dx_neg      = x1_e < x0_e;
    s1_seg_next.dx_mag      = (x1_e < x0_e) ? 32'(x0_e - x1_e) : 32'(x1_e - x0_e);
    s1_seg_next.dy_neg      = y1_e < y0_e;
    s1_seg_next.dy_mag      = (y1_e < y0_e) ? 32'(y0_e - y1_e) : 32'(y1_e - y0_e);
  end

  logic                          v_s1;
  lnclip_pkg::seg_t              s1_seg;
  logic [lnclip_pkg::CLIP_N_W-1:0] s1_num;
  logic [lnclip_pkg::CLIP_D_W-1:0] s1_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
    end else begin
      v_s1 <= v_s0;
    end
  end

  always_ff @(posedge clk) begin
    s1_seg <= s1_seg_next;
    s1_num <= {num_sel, {lnclip_pkg::T_BITS{1'b0}}};
    s1_den <= den_sel;
  end

  // ---------------- interpolation fraction ----------------
  logic [lnclip_pkg::CLIP_Q_W-1:0] t_frac;
  logic                            t_ovf;
  logic [CLIP_LAT-1:0]             clip_v;
  lnclip_pkg::seg_t                clip_seg [0:CLIP_LAT-1];

  lnclip_div_pipe #(
    .NUM_W (lnclip_pkg::CLIP_N_W),
    .DEN_W (lnclip_pkg::CLIP_D_W),
    .Q_W   (lnclip_pkg::CLIP_Q_W)
  ) u_clip_div (
    .clk      (clk),
    .dividend (s1_num),
    .divisor  (s1_den),
    .quotient (t_frac),
    .overflow (t_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_v <= '0;
    end else begin
      clip_v <= {clip_v[CLIP_LAT-2:0], v_s1};
    end
  end

  always_ff @(posedge clk) begin
    clip_seg[0] <= s1_seg;
    for (int k = 1; k < CLIP_LAT; k++) begin
      clip_seg[k] <= clip_seg[k-1];
    end
  end

  // ---------------- P1..P3: move the clipped endpoint ----------------
  logic             v_p1, v_p2, v_p3;
  lnclip_pkg::seg_t p1_seg, p2_seg, p3_seg;
  logic [63:0]      p1_prod_x, p1_prod_y;
  logic [31:0]      p2_step_x, p2_step_y;
  logic [63:0]      round_x, round_y;
  logic [32:0]      new_x, new_y;
  lnclip_pkg::seg_t p3_seg_next;

  always_comb begin
    round_x = p1_prod_x + (64'd1 << (lnclip_pkg::T_BITS - 1));
    round_y = p1_prod_y + (64'd1 << (lnclip_pkg::T_BITS - 1));
  end

  always_comb begin
    p3_seg_next = p2_seg;
    new_x = p2_seg.dx_neg ? ({p2_seg.x0[31], p2_seg.x0} - {1'b0, p2_step_x})
                          : ({p2_seg.x0[31], p2_seg.x0} + {1'b0, p2_step_x});
    new_y = p2_seg.dy_neg ? ({p2_seg.y0[31], p2_seg.y0} - {1'b0, p2_step_y})
                          : ({p2_seg.y0[31], p2_seg.y0} + {1'b0, p2_step_y});
    if (p2_seg.clip_first) begin
      p3_seg_next.x0 = new_x[31:0];
      p3_seg_next.y0 = new_y[31:0];
      p3_seg_next.z0 = {1'b0, p2_seg.nz};
    end else if (p2_seg.clip_second) begin
      p3_seg_next.x1 = new_x[31:0];
      p3_seg_next.y1 = new_y[31:0];
      p3_seg_next.z1 = {1'b0, p2_seg.nz};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p1 <= 1'b0;
      v_p2 <= 1'b0;
      v_p3 <= 1'b0;
    end else begin
      v_p1 <= clip_v[CLIP_LAT-1];
      v_p2 <= v_p1;
      v_p3 <= v_p2;
    end
  end

  always_ff @(posedge clk) begin
    p1_seg    <= clip_seg[CLIP_LAT-1];
    p1_prod_x <= clip_seg[CLIP_LAT-1].dx_mag * t_frac;
    p1_prod_y <= clip_seg[CLIP_LAT-1].dy_mag * t_frac;
    p2_seg    <= p1_seg;
    p2_step_x <= round_x[62:31];
    p2_step_y <= round_y[62:31];
    p3_seg    <= p3_seg_next;
  end

  // ---------------- R1..R3: projection numerators ----------------
  // lane order: x0, y0, x1, y1
  logic [31:0] lane_c [0:LANES-1];
  logic [30:0] lane_z [0:LANES-1];
  logic [11:0] lane_ctr [0:LANES-1];

  always_comb begin
    lane_c[0]   = p3_seg.x0;
    lane_c[1]   = p3_seg.y0;
    lane_c[2]   = p3_seg.x1;
    lane_c[3]   = p3_seg.y1;
    lane_z[0]   = p3_seg.z0[30:0];
    lane_z[1]   = p3_seg.z0[30:0];
    lane_z[2]   = p3_seg.z1[30:0];
    lane_z[3]   = p3_seg.z1[30:0];
    lane_ctr[0] = screen_width[12:1];
    lane_ctr[1] = screen_height[12:1];
    lane_ctr[2] = screen_width[12:1];
    lane_ctr[3] = screen_height[12:1];
  end

  logic                               v_r1, v_r2, v_r3;
  logic                               r1_drop, r2_drop, r3_drop;
  logic [31:0]                        r1_colour, r2_colour, r3_colour;
  logic signed [lnclip_pkg::SUM_W-1:0] r1_pc  [0:LANES-1];
  logic [42:0]                        r1_pz  [0:LANES-1];
  logic signed [lnclip_pkg::SUM_W-1:0] r2_sum [0:LANES-1];
  logic [lnclip_pkg::MAG_W-1:0]        r3_mag [0:LANES-1];
  logic [LANES-1:0]                   r3_neg;
  logic [30:0]                        r1_z [0:LANES-1];
  logic [30:0]                        r2_z [0:LANES-1];
  logic [30:0]                        r3_z [0:LANES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r1 <= 1'b0;
      v_r2 <= 1'b0;
      v_r3 <= 1'b0;
    end else begin
      v_r1 <= v_p3;
      v_r2 <= v_r1;
      v_r3 <= v_r2;
    end
  end

  always_ff @(posedge clk) begin
    r1_drop   <= p3_seg.drop;
    r1_colour <= p3_seg.colour;
    r2_drop   <= r1_drop;
    r2_colour <= r1_colour;
    r3_drop   <= r2_drop;
    r3_colour <= r2_colour;
    for (int l = 0; l < LANES; l++) begin
      r1_pc[l]  <= $signed(lane_c[l]) * $signed({1'b0, p3_seg.focal});
      r1_pz[l]  <= lane_ctr[l] * lane_z[l];
      r1_z[l]   <= lane_z[l];
      r2_sum[l] <= r1_pc[l] + $signed({4'b0000, r1_pz[l]});
      r2_z[l]   <= r1_z[l];
      r3_neg[l] <= r2_sum[l][lnclip_pkg::SUM_W-1];
      r3_mag[l] <= r2_sum[l][lnclip_pkg::SUM_W-1]
                   ? lnclip_pkg::MAG_W'(-r2_sum[l])
                   : r2_sum[l][lnclip_pkg::MAG_W-1:0];
      r3_z[l]   <= r2_z[l];
    end
  end

  // ---------------- projection dividers ----------------
  logic [lnclip_pkg::PROJ_Q_W-1:0] pq     [0:LANES-1];
  logic [LANES-1:0]                pq_ovf;

  for (genvar l = 0; l < LANES; l++) begin : g_proj
    lnclip_div_pipe #(
      .NUM_W (lnclip_pkg::MAG_W),
      .DEN_W (lnclip_pkg::PROJ_D_W),
      .Q_W   (lnclip_pkg::PROJ_Q_W)
    ) u_proj_div (
      .clk      (clk),
      .dividend (r3_mag[l]),
      .divisor  (r3_z[l]),
      .quotient (pq[l]),
      .overflow (pq_ovf[l])
    );
  end

  logic [PROJ_LAT-1:0]    proj_v;
  lnclip_pkg::proj_side_t proj_side [0:PROJ_LAT-1];
  lnclip_pkg::proj_side_t r3_side;

  always_comb begin
    r3_side.neg    = r3_neg;
    r3_side.drop   = r3_drop;
    r3_side.colour = r3_colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_v <= '0;
    end else begin
      proj_v <= {proj_v[PROJ_LAT-2:0], v_r3};
    end
  end

  always_ff @(posedge clk) begin
    proj_side[0] <= r3_side;
    for (int k = 1; k < PROJ_LAT; k++) begin
      proj_side[k] <= proj_side[k-1];
    end
  end

  // ---------------- F: sign, centre flip, saturate ----------------
  lnclip_pkg::proj_side_t fs;
  logic [lnclip_pkg::PROJ_Q_W-1:0] qm [0:LANES-1];
  logic signed [lnclip_pkg::PROJ_Q_W:0] qs [0:LANES-1];
  logic signed [20:0] qe [0:LANES-1];
  logic signed [20:0] h_m1;
  logic signed [15:0] sx0, sy0, sx1, sy1;

  always_comb begin
    fs   = proj_side[PROJ_LAT-1];
    h_m1 = $signed({8'b0, screen_height}) - 21'sd1;
    for (int l = 0; l < LANES; l++) begin
      // a quotient past 18 bits saturates either way
      qm[l] = pq_ovf[l] ? '1 : pq[l];
      qs[l] = fs.neg[l] ? -$signed({1'b0, qm[l]}) : $signed({1'b0, qm[l]});
      qe[l] = 21'(qs[l]);
    end
    sx0 = lnclip_pkg::sat16(qe[0]);
    sy0 = lnclip_pkg::sat16(h_m1 - qe[1]);
    sx1 = lnclip_pkg::sat16(qe[2]);
    sy1 = lnclip_pkg::sat16(h_m1 - qe[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= proj_v[PROJ_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    visible    <= !fs.drop;
    screen_x0  <= fs.drop ? '0 : sx0;
    screen_y0  <= fs.drop ? '0 : sy0;
    screen_x1  <= fs.drop ? '0 : sx1;
    screen_y1  <= fs.drop ? '0 : sy1;
    colour_out <= fs.colour;
  end

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result strobe missing after accepted beat");

  a_frac_fits: assert property (@(posedge clk) disable iff (rst)
    (clip_v[CLIP_LAT-1] && (clip_seg[CLIP_LAT-1].clip_first ||
                            clip_seg[CLIP_LAT-1].clip_second)) |-> !t_ovf)
    else $error("interpolation fraction overflowed");

  a_depth_clipped: assert property (@(posedge clk) disable iff (rst)
    (v_p3 && !p3_seg.drop) |->
      ($signed(p3_seg.z0) >= $signed({1'b0, p3_seg.nz}) &&
       $signed(p3_seg.z1) >= $signed({1'b0, p3_seg.nz})))
    else $error("endpoint left in front of near plane");

  a_one_path: assert property (@(posedge clk) disable iff (rst)
    v_s1 |-> $countones({s1_seg.drop, s1_seg.clip_first, s1_seg.clip_second}) <= 1)
    else $error("segment classified two ways");

endmodule

// ===== test/line_projection_checker.sv =====
`timescale 1ns / 1ps

module line_projection_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic [13:0]        focal_scale,
  input  logic [31:0]        line_colour,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               done,
  input  logic               visible,
  input  logic signed [15:0] screen_x0,
  input  logic signed [15:0] screen_y0,
  input  logic signed [15:0] screen_x1,
  input  logic signed [15:0] screen_y1,
  input  logic [31:0]        colour_out,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic               vis;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [31:0]        colour;
  } line_px_t;

  line_px_t    expected_lines[$];
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [30:0] near_q;

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // move a toward b by fraction t / 2^31, rounding halves away from zero
  function automatic longint slide(longint a, longint b, longint unsigned t);
    longint d;
    longint unsigned mag;
    longint unsigned q;
    d = b - a;
    mag = (d < 0) ? -d : d;
    q = (mag * t + (64'd1 << (lnclip_pkg::T_BITS - 1))) >> lnclip_pkg::T_BITS;
    return (d < 0) ? a - longint'(q) : a + longint'(q);
  endfunction

  function automatic longint persp(longint c, longint z, longint f, longint ctr);
    return (c * f + ctr * z) / z;
  endfunction

  function automatic line_px_t project_segment(
      longint x1, longint y1, longint z1, longint x2, longint y2, longint z2,
      longint f, logic [31:0] colour);
    line_px_t r;
    longint nz, cx, cy, hh;
    longint unsigned t;
    r = '0;
    r.colour = colour;
    nz = (near_q == 0) ? 1 : longint'(near_q);
    cx = width_q / 2;
    cy = height_q / 2;
    hh = height_q;
    if (z1 < nz && z2 < nz) return r;
    if (z1 < nz) begin
      t = (longint'(nz - z1) << lnclip_pkg::T_BITS) / longint'(z2 - z1);
      x1 = slide(x1, x2, t);
      y1 = slide(y1, y2, t);
      z1 = nz;
    end else if (z2 < nz) begin
      t = (longint'(z1 - nz) << lnclip_pkg::T_BITS) / longint'(z1 - z2);
      x2 = slide(x1, x2, t);
      y2 = slide(y1, y2, t);
      z2 = nz;
    end
    r.vis = 1'b1;
    r.x0 = clamp16(persp(x1, z1, f, cx));
    r.y0 = clamp16(hh - 1 - persp(y1, z1, f, cy));
    r.x1 = clamp16(persp(x2, z2, f, cx));
    r.y1 = clamp16(hh - 1 - persp(y2, z2, f, cy));
    return r;
  endfunction

  assign pending = expected_lines.size();

  always @(posedge clk) begin
    line_px_t e;
    if (rst) begin
      width_q  <= lnclip_pkg::SCREEN_WIDTH_RST;
      height_q <= lnclip_pkg::SCREEN_HEIGHT_RST;
      near_q   <= lnclip_pkg::NEAR_PLANE_Z_RST;
      expected_lines.delete();
      errors   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lnclip_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data[12:0];
          lnclip_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data[12:0];
          lnclip_pkg::REG_NEAR_PLANE_Z:  near_q   <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_lines.push_back(project_segment(start_x, start_y, start_z, end_x,
            end_y, end_z, focal_scale, line_colour));
      if (done) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected beat, actual vis=%0d x0=%0d y0=%0d x1=%0d y1=%0d",
                   $time, visible, screen_x0, screen_y0, screen_x1, screen_y1);
          errors <= errors + 1;
        end else begin
          e = expected_lines.pop_front();
          if (e != {visible, screen_x0, screen_y0, screen_x1, screen_y1, colour_out}) begin
            $display("%0t: mismatch expected vis=%0d x0=%0d y0=%0d x1=%0d y1=%0d c=%h",
                     $time, e.vis, e.x0, e.y0, e.x1, e.y1, e.colour);
            $display("%0t:          actual   vis=%0d x0=%0d y0=%0d x1=%0d y1=%0d c=%h",
                     $time, visible, screen_x0, screen_y0, screen_x1, screen_y1,
                     colour_out);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int DRAIN = 70;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, visible;
  logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
  logic [13:0] focal_scale;
  logic [31:0] line_colour, cfg_data, colour_out;
  logic [1:0] cfg_index;
  logic signed [15:0] screen_x0, screen_y0, screen_x1, screen_y1;
  int errors, pending;
  logic [30:0] near_now;

  line_near_clip_perspective_project_unit i_dut (.*);
  line_projection_checker i_chk (.*);

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lnclip_pkg::REG_NEAR_PLANE_Z) near_now = val[30:0];
  endtask

  // wait for the pipeline to empty, then hold off for the drain time
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_beat(logic [31:0] sx, sy, sz, ex, ey, ez, logic [13:0] f,
                           logic [31:0] c);
    start_x <= sx; start_y <= sy; start_z <= sz;
    end_x <= ex; end_y <= ey; end_z <= ez;
    focal_scale <= f; line_colour <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
    endcase
  endfunction

  // depths mostly near the clip plane so crossing segments are common
  function automatic logic [31:0] depth();
    longint nz;
    nz = (near_now == 0) ? 1 : near_now;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'(nz + $urandom_range(0, 2 ** 22));
      2: return 32'(nz - $urandom_range(0, 2 ** 20));
      default: return 32'(nz + $signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        send_beat(coord(), coord(), depth(), coord(), coord(), depth(),
                  $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'($urandom_range(0, 800)),
                  $urandom);
        burst--; n--;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    start_x = '0; start_y = '0; start_z = '0; end_x = '0; end_y = '0; end_z = '0;
    focal_scale = '0; line_colour = '0;
    near_now = lnclip_pkg::NEAR_PLANE_Z_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // both in front, only start in front, only end in front, both beyond
    send_beat(100, 200, 10, 300, 400, 20, 256, 32'h11111111);
    send_beat(32'h00010000, 32'h00020000, 32'hffff0000, 32'hfffe0000, 32'h00030000,
              32'h00100000, 500, 32'h22222222);
    send_beat(32'h00050000, 32'hfff00000, 32'h00200000, 32'h00010000, 32'h00010000,
              32'h80000000, 1000, 32'h33333333);
    send_beat(32'h00010000, 32'h00010000, 32'h00020000, 32'hffff0000, 32'hffff0000,
              32'h00030000, 300, 32'h44444444);
    send_beat(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 14'h3fff, 32'hffffffff);
    send_beat(32'h7fffffff, 32'h7fffffff, 655, 32'h80000000, 32'h80000000, 655,
              14'h3fff, 32'h0);
    send_beat(32'h12345678, 32'h9abcdef0, 32'h00400000, 32'h0, 32'h0, 32'h00400000,
              0, 32'h5a5a5a5a);
    send_beat(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              32'h80000000, 16383, 32'ha5a5a5a5);
    send_beat(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 16383, 32'h0f0f0f0f);
    send_beat(5, 5, 654, 5, 5, 655, 1, 32'hf0f0f0f0);
    start <= 1'b0;

    settle();
    write_reg(lnclip_pkg::REG_SCREEN_WIDTH, 1);
    write_reg(lnclip_pkg::REG_SCREEN_HEIGHT, 1);
    write_reg(lnclip_pkg::REG_NEAR_PLANE_Z, 0);
    write_reg(REG_SPARE, 32'hffffffff);
    send_beat(3, 4, 0, 5, 6, 32'h00010000, 16383, 1);
    send_beat(7, 8, 32'hffffffff, 9, 9, 32'h80000000, 16383, 2);
    random_phase(150);

    settle();
    write_reg(lnclip_pkg::REG_SCREEN_WIDTH, 4096);
    write_reg(lnclip_pkg::REG_SCREEN_HEIGHT, 4096);
    write_reg(lnclip_pkg::REG_NEAR_PLANE_Z, 32'h7fffffff);
    send_beat(32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0, 32'h7ffffffe, 16383, 3);
    random_phase(150);

    settle();
    write_reg(lnclip_pkg::REG_SCREEN_WIDTH, 32'hffffffff);
    write_reg(lnclip_pkg::REG_SCREEN_HEIGHT, 0);
    write_reg(lnclip_pkg::REG_NEAR_PLANE_Z, 32'h0000ffff);
    random_phase(150);

    settle();
    write_reg(lnclip_pkg::REG_SCREEN_WIDTH, 640);
    write_reg(lnclip_pkg::REG_SCREEN_HEIGHT, 480);
    write_reg(lnclip_pkg::REG_NEAR_PLANE_Z, 655);
    random_phase(300);

    repeat (2) begin
      settle();
      write_reg(lnclip_pkg::REG_SCREEN_WIDTH, $urandom);
      write_reg(lnclip_pkg::REG_SCREEN_HEIGHT, $urandom);
      write_reg(lnclip_pkg::REG_NEAR_PLANE_Z,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2 ** 20));
      random_phase(190);
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
